// File: hdl/rrcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rrcd_pkg
// Shared widths, status codes and sideband types for the closest distance
// pipeline between two 3D lines.
// ============================================================================
package rrcd_pkg;

    // Field and datapath widths.
    localparam int IN_W  = 16;          // Q8.8 input coordinate
    localparam int DP_W  = IN_W + 1;    // origin difference
    localparam int RW    = 64;          // divisor and partial remainder
    localparam int QW    = 40;          // quotient bits, one per division cell
    localparam int NW    = RW + QW;     // dividend
    localparam int GW    = 18;          // gap result, one bit per root cell
    localparam int TW    = 24;          // line parameter result

    // Lanes of the division chain.
    localparam int NLANE    = 3;
    localparam int LANE_T1  = 0;
    localparam int LANE_T2  = 1;
    localparam int LANE_GAP = 2;

    // Result status codes.
    localparam logic [1:0] ST_SKEW     = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_DEGEN    = 2'd2;

    // Saturation limits.
    localparam logic [GW-1:0] GAP_MAX  = {GW{1'b1}};
    localparam logic [TW-1:0] TMAG_POS = {1'b0, {(TW-1){1'b1}}};
    localparam logic [TW-1:0] TMAG_NEG = {1'b1, {(TW-1){1'b0}}};

    // Sideband that travels next to the division cells.
    typedef struct packed {
        logic [1:0] status;
        logic       neg1;
        logic       neg2;
        logic       sat1;
        logic       sat2;
        logic       satg;
    } div_side_t;

    // Sideband that travels next to the root cells.
    typedef struct packed {
        logic [1:0]    status;
        logic [TW-1:0] t1;
        logic [TW-1:0] t2;
    } root_side_t;

endpackage
`default_nettype wire

// File: hdl/ray_ray_closest_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ray_ray_closest_distance
// Closest distance and closest point parameters of two 3D lines, one line
// pair per transaction, fully pipelined.
// ============================================================================
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid / in_stall     | r1/r2 origin and direction, Q8.8
//  out     | out_valid / out_stall   | gap_length, param_first/second, status
//
//  One transaction enters per cycle while in_stall is low.
//  Seven front stages feed the 40-cell restoring division chain (three lanes
//  side by side), a rounding stage and the 18-cell square root chain.
//  Reset clears only the valid bits; no clearing pass is needed.
//  While a result waits in the output register under out_stall, the whole
//  pipeline holds and in_stall is raised.
// ============================================================================
module ray_ray_closest_distance
    import rrcd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [15:0]  r1_origin_x,
    input  wire logic signed [15:0]  r1_origin_y,
    input  wire logic signed [15:0]  r1_origin_z,
    input  wire logic signed [15:0]  r1_dir_x,
    input  wire logic signed [15:0]  r1_dir_y,
    input  wire logic signed [15:0]  r1_dir_z,
    input  wire logic signed [15:0]  r2_origin_x,
    input  wire logic signed [15:0]  r2_origin_y,
    input  wire logic signed [15:0]  r2_origin_z,
    input  wire logic signed [15:0]  r2_dir_x,
    input  wire logic signed [15:0]  r2_dir_y,
    input  wire logic signed [15:0]  r2_dir_z,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic        [17:0]       gap_length,
    output logic signed [23:0]       param_first,
    output logic signed [23:0]       param_second,
    output logic        [1:0]        status
);

    logic adv;

    // Front valid bits.
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s5_vld_reg, s6_vld_reg, s7_vld_reg;

    // Stage 1: directions and origin difference.
    logic signed [IN_W-1:0] s1_d1_reg [3];
    logic signed [IN_W-1:0] s1_d2_reg [3];
    logic signed [DP_W-1:0] s1_dp_reg [3];

    // Stage 2: products.
    logic signed [31:0]     s2_p11_reg [3];
    logic signed [31:0]     s2_p22_reg [3];
    logic signed [31:0]     s2_p12_reg [3];
    logic signed [31:0]     s2_cm_reg  [6];
    logic signed [32:0]     s2_am_reg  [6];
    logic signed [32:0]     s2_pd1_reg [3];
    logic signed [32:0]     s2_pd2_reg [3];
    logic signed [DP_W-1:0] s2_dp_reg  [3];

    // Stage 3: dot products and cross products.
    logic        [31:0]     s3_v11_reg;
    logic        [31:0]     s3_v22_reg;
    logic signed [33:0]     s3_v12_reg;
    logic signed [32:0]     s3_c_reg [3];
    logic signed [33:0]     s3_a_reg [3];
    logic signed [34:0]     s3_dpv1_reg;
    logic signed [34:0]     s3_dpv2_reg;
    logic signed [DP_W-1:0] s3_dp_reg [3];

    // Stage 4: second level products.
    logic [33:0]            m12_w;
    logic [33:0]            amag_w [3];
    logic [63:0]            s4_vv_reg;
    logic [63:0]            s4_m12sq_reg;
    logic signed [69:0]     s4_n1a_reg, s4_n1b_reg, s4_n2a_reg, s4_n2b_reg;
    logic signed [51:0]     s4_sp_reg [3];
    logic [63:0]            s4_aq_reg [3];
    logic [31:0]            s4_v11_reg;
    logic                   s4_v11z_reg;

    // Stage 5: determinant, numerators, triple product.
    logic [RW-1:0]          s5_d_reg;
    logic signed [69:0]     s5_n1_reg, s5_n2_reg;
    logic signed [51:0]     s5_s_reg;
    logic [65:0]            s5_asum_reg;
    logic [31:0]            s5_v11_reg;
    logic                   s5_v11z_reg;

    // Stage 6: magnitudes and split square of the triple product.
    logic [68:0]            n1_mag_w, n2_mag_w;
    logic [51:0]            s_mag_w;
    logic [68:0]            s6_n1_reg, s6_n2_reg;
    logic                   s6_neg1_reg, s6_neg2_reg;
    logic [51:0]            s6_hh_reg;
    logic [50:0]            s6_hl_reg;
    logic [49:0]            s6_ll_reg;
    logic [RW-1:0]          s6_d_reg;
    logic [65:0]            s6_asum_reg;
    logic [31:0]            s6_v11_reg;
    logic [1:0]             s6_status_reg;

    // Stage 7: dividends and divisors for the three lanes.
    logic [101:0]           ssq_w;
    logic [NW-1:0]          s7_num_reg [NLANE];
    logic [RW-1:0]          s7_den_reg [NLANE];
    logic [1:0]             s7_status_reg;
    logic                   s7_neg1_reg, s7_neg2_reg;

    // Division chain.
    logic [RW-1:0]          ch_den [NLANE][QW+1];
    logic [RW-1:0]          ch_r   [NLANE][QW+1];
    logic [QW-1:0]          ch_x   [NLANE][QW+1];
    div_side_t              ds_in_w;
    div_side_t              ds_reg [QW];
    logic [QW-1:0]          dv_vld_reg;

    // Rounding stage.
    logic [TW-1:0]          tv_w [2];
    logic [QW-1:0]          q_gap_w;
    logic [QW-1:0]          pq_reg;
    root_side_t             ps_reg;
    logic                   pv_vld_reg;

    // Root chain.
    logic [GW-1:0]          rg [GW+1];
    logic [QW-1:0]          rq [GW+1];
    root_side_t             rs_reg [GW];
    logic [GW-1:0]          rv_vld_reg;

    // Output register.
    logic                   out_valid_reg;
    logic [GW-1:0]          out_gap_reg;
    logic [TW-1:0]          out_t1_reg, out_t2_reg;
    logic [1:0]             out_status_reg;

    // The pipeline moves unless a finished result is held by the sink.
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Valid bits for every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s6_vld_reg    <= 1'b0;
            s7_vld_reg    <= 1'b0;
            dv_vld_reg    <= '0;
            pv_vld_reg    <= 1'b0;
            rv_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            s6_vld_reg    <= s5_vld_reg;
            s7_vld_reg    <= s6_vld_reg;
            dv_vld_reg    <= {dv_vld_reg[QW-2:0], s7_vld_reg};
            pv_vld_reg    <= dv_vld_reg[QW-1];
            rv_vld_reg    <= {rv_vld_reg[GW-2:0], pv_vld_reg};
            out_valid_reg <= rv_vld_reg[GW-1];
        end
    end

    // Stage 1: capture directions and form the origin difference.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_d1_reg[0] <= r1_dir_x;
            s1_d1_reg[1] <= r1_dir_y;
            s1_d1_reg[2] <= r1_dir_z;
            s1_d2_reg[0] <= r2_dir_x;
            s1_d2_reg[1] <= r2_dir_y;
            s1_d2_reg[2] <= r2_dir_z;
            s1_dp_reg[0] <= {r2_origin_x[15], r2_origin_x} - {r1_origin_x[15], r1_origin_x};
            s1_dp_reg[1] <= {r2_origin_y[15], r2_origin_y} - {r1_origin_y[15], r1_origin_y};
            s1_dp_reg[2] <= {r2_origin_z[15], r2_origin_z} - {r1_origin_z[15], r1_origin_z};
        end
    end

    // Stage 2: all first level products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_p11_reg[i] <= s1_d1_reg[i] * s1_d1_reg[i];
                s2_p22_reg[i] <= s1_d2_reg[i] * s1_d2_reg[i];
                s2_p12_reg[i] <= s1_d1_reg[i] * s1_d2_reg[i];
                s2_pd1_reg[i] <= s1_dp_reg[i] * s1_d1_reg[i];
                s2_pd2_reg[i] <= s1_dp_reg[i] * s1_d2_reg[i];
                s2_dp_reg[i]  <= s1_dp_reg[i];
            end
            s2_cm_reg[0] <= s1_d1_reg[1] * s1_d2_reg[2];
            s2_cm_reg[1] <= s1_d1_reg[2] * s1_d2_reg[1];
            s2_cm_reg[2] <= s1_d1_reg[2] * s1_d2_reg[0];
            s2_cm_reg[3] <= s1_d1_reg[0] * s1_d2_reg[2];
            s2_cm_reg[4] <= s1_d1_reg[0] * s1_d2_reg[1];
            s2_cm_reg[5] <= s1_d1_reg[1] * s1_d2_reg[0];
            s2_am_reg[0] <= s1_dp_reg[1] * s1_d1_reg[2];
            s2_am_reg[1] <= s1_dp_reg[2] * s1_d1_reg[1];
            s2_am_reg[2] <= s1_dp_reg[2] * s1_d1_reg[0];
            s2_am_reg[3] <= s1_dp_reg[0] * s1_d1_reg[2];
            s2_am_reg[4] <= s1_dp_reg[0] * s1_d1_reg[1];
            s2_am_reg[5] <= s1_dp_reg[1] * s1_d1_reg[0];
        end
    end

    // Stage 3: dot products, d1 x d2 and dp x d1.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_v11_reg  <= 32'(s2_p11_reg[0]) + 32'(s2_p11_reg[1]) + 32'(s2_p11_reg[2]);
            s3_v22_reg  <= 32'(s2_p22_reg[0]) + 32'(s2_p22_reg[1]) + 32'(s2_p22_reg[2]);
            s3_v12_reg  <= 34'(s2_p12_reg[0]) + 34'(s2_p12_reg[1]) + 34'(s2_p12_reg[2]);
            s3_dpv1_reg <= 35'(s2_pd1_reg[0]) + 35'(s2_pd1_reg[1]) + 35'(s2_pd1_reg[2]);
            s3_dpv2_reg <= 35'(s2_pd2_reg[0]) + 35'(s2_pd2_reg[1]) + 35'(s2_pd2_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                s3_c_reg[i]  <= 33'(s2_cm_reg[2*i]) - 33'(s2_cm_reg[2*i+1]);
                s3_a_reg[i]  <= 34'(s2_am_reg[2*i]) - 34'(s2_am_reg[2*i+1]);
                s3_dp_reg[i] <= s2_dp_reg[i];
            end
        end
    end

    // Magnitudes ahead of the unsigned squares.
    always_comb
    begin
        m12_w = s3_v12_reg[33] ? 34'(-s3_v12_reg) : 34'(s3_v12_reg);
        for (int i = 0; i < 3; i++)
        begin
            amag_w[i] = s3_a_reg[i][33] ? 34'(-s3_a_reg[i]) : 34'(s3_a_reg[i]);
        end
    end

    // Stage 4: second level products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_vv_reg    <= s3_v11_reg * s3_v22_reg;
            s4_m12sq_reg <= m12_w[31:0] * m12_w[31:0];
            s4_n1a_reg   <= $signed({1'b0, s3_v22_reg}) * s3_dpv1_reg;
            s4_n1b_reg   <= s3_v12_reg * s3_dpv2_reg;
            s4_n2a_reg   <= s3_v12_reg * s3_dpv1_reg;
            s4_n2b_reg   <= $signed({1'b0, s3_v11_reg}) * s3_dpv2_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_sp_reg[i] <= s3_dp_reg[i] * s3_c_reg[i];
                s4_aq_reg[i] <= amag_w[i][31:0] * amag_w[i][31:0];
            end
            s4_v11_reg  <= s3_v11_reg;
            s4_v11z_reg <= (s3_v11_reg == '0);
        end
    end

    // Stage 5: determinant, numerators and sums.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_d_reg    <= s4_vv_reg - s4_m12sq_reg;
            s5_n1_reg   <= s4_n1a_reg - s4_n1b_reg;
            s5_n2_reg   <= s4_n2a_reg - s4_n2b_reg;
            s5_s_reg    <= s4_sp_reg[0] + s4_sp_reg[1] + s4_sp_reg[2];
            s5_asum_reg <= 66'(s4_aq_reg[0]) + 66'(s4_aq_reg[1]) + 66'(s4_aq_reg[2]);
            s5_v11_reg  <= s4_v11_reg;
            s5_v11z_reg <= s4_v11z_reg;
        end
    end

    // Magnitudes of the numerators and of the triple product.
    assign n1_mag_w = s5_n1_reg[69] ? 69'(-s5_n1_reg) : 69'(s5_n1_reg);
    assign n2_mag_w = s5_n2_reg[69] ? 69'(-s5_n2_reg) : 69'(s5_n2_reg);
    assign s_mag_w  = s5_s_reg[51] ? 52'(-s5_s_reg) : 52'(s5_s_reg);

    // Stage 6: classify and square the triple product in halves.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_n1_reg   <= n1_mag_w;
            s6_n2_reg   <= n2_mag_w;
            s6_neg1_reg <= s5_n1_reg[69];
            s6_neg2_reg <= s5_n2_reg[69];
            s6_hh_reg   <= s_mag_w[50:25] * s_mag_w[50:25];
            s6_hl_reg   <= s_mag_w[50:25] * s_mag_w[24:0];
            s6_ll_reg   <= s_mag_w[24:0] * s_mag_w[24:0];
            s6_d_reg    <= s5_d_reg;
            s6_asum_reg <= s5_asum_reg;
            s6_v11_reg  <= s5_v11_reg;
            if (s5_v11z_reg)
            begin
                s6_status_reg <= ST_DEGEN;
            end
            else if (s5_d_reg == '0)
            begin
                s6_status_reg <= ST_PARALLEL;
            end
            else
            begin
                s6_status_reg <= ST_SKEW;
            end
        end
    end

    // Square of the triple product from its partial products.
    assign ssq_w = (102'(s6_hh_reg) << 50) + (102'(s6_hl_reg) << 26) + 102'(s6_ll_reg);

    // Stage 7: scaled dividends and divisors.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_num_reg[LANE_T1] <= {27'd0, s6_n1_reg, 8'd0};
            s7_num_reg[LANE_T2] <= {27'd0, s6_n2_reg, 8'd0};
            s7_den_reg[LANE_T1] <= s6_d_reg;
            s7_den_reg[LANE_T2] <= s6_d_reg;
            if (s6_status_reg == ST_SKEW)
            begin
                s7_num_reg[LANE_GAP] <= {ssq_w, 2'b00};
                s7_den_reg[LANE_GAP] <= s6_d_reg;
            end
            else
            begin
                s7_num_reg[LANE_GAP] <= {36'd0, s6_asum_reg, 2'b00};
                s7_den_reg[LANE_GAP] <= {32'd0, s6_v11_reg};
            end
            s7_status_reg <= s6_status_reg;
            s7_neg1_reg   <= s6_neg1_reg;
            s7_neg2_reg   <= s6_neg2_reg;
        end
    end

    // Quotients too large for the chain are flagged and saturated later.
    always_comb
    begin
        ds_in_w.status = s7_status_reg;
        ds_in_w.neg1   = s7_neg1_reg;
        ds_in_w.neg2   = s7_neg2_reg;
        ds_in_w.sat1   = s7_num_reg[LANE_T1][NW-1:QW] >= s7_den_reg[LANE_T1];
        ds_in_w.sat2   = s7_num_reg[LANE_T2][NW-1:QW] >= s7_den_reg[LANE_T2];
        ds_in_w.satg   = s7_num_reg[LANE_GAP][NW-1:QW] >= s7_den_reg[LANE_GAP];
    end

    // Division chain: three lanes of QW cells each.
    for (genvar l = 0; l < NLANE; l++)
    begin : g_lane
        assign ch_den[l][0] = s7_den_reg[l];
        assign ch_r[l][0]   = s7_num_reg[l][NW-1:QW];
        assign ch_x[l][0]   = s7_num_reg[l][QW-1:0];
        for (genvar k = 0; k < QW; k++)
        begin : g_step
            rrcd_div_cell u_cell (
                .clk     (clk),
                .en      (adv),
                .den_in  (ch_den[l][k]),
                .r_in    (ch_r[l][k]),
                .x_in    (ch_x[l][k]),
                .den_out (ch_den[l][k+1]),
                .r_out   (ch_r[l][k+1]),
                .x_out   (ch_x[l][k+1])
            );
        end
    end

    // Sideband beside the division chain.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_reg[0] <= ds_in_w;
            for (int k = 1; k < QW; k++)
            begin
                ds_reg[k] <= ds_reg[k-1];
            end
        end
    end

    // Round the line parameters to nearest, ties away from zero, and saturate; zero them unless skew.
    always_comb
    begin
        logic          rnd;
        logic [QW:0]   qr;
        logic          neg;
        logic          sat;
        logic [TW-1:0] lim;
        logic [TW-1:0] mag;
        for (int l = 0; l < 2; l++)
        begin
            rnd = {ch_r[l][QW], 1'b0} >= {1'b0, ch_den[l][QW]};
            qr  = {1'b0, ch_x[l][QW]} + (QW+1)'(rnd);
            neg = (l == LANE_T1) ? ds_reg[QW-1].neg1 : ds_reg[QW-1].neg2;
            sat = (l == LANE_T1) ? ds_reg[QW-1].sat1 : ds_reg[QW-1].sat2;
            lim = neg ? TMAG_NEG : TMAG_POS;
            mag = (sat || (qr > (QW+1)'(lim))) ? lim : qr[TW-1:0];
            if (ds_reg[QW-1].status != ST_SKEW)
            begin
                tv_w[l] = '0;
            end
            else
            begin
                tv_w[l] = neg ? -mag : mag;
            end
        end
    end

    // Ratio for the root; an empty first direction or overflow forces the cap.
    assign q_gap_w = (ds_reg[QW-1].satg || (ds_reg[QW-1].status == ST_DEGEN))
                   ? {QW{1'b1}} : ch_x[LANE_GAP][QW];

    // Rounding stage register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pq_reg        <= q_gap_w;
            ps_reg.status <= ds_reg[QW-1].status;
            ps_reg.t1     <= tv_w[LANE_T1];
            ps_reg.t2     <= tv_w[LANE_T2];
        end
    end

    // Root chain: one result bit per cell, most significant first.
    assign rg[0] = '0;
    assign rq[0] = pq_reg;
    for (genvar k = 0; k < GW; k++)
    begin : g_root
        rrcd_root_cell #(
            .BIT (GW - 1 - k)
        ) u_cell (
            .clk   (clk),
            .en    (adv),
            .g_in  (rg[k]),
            .q_in  (rq[k]),
            .g_out (rg[k+1]),
            .q_out (rq[k+1])
        );
    end

    // Sideband beside the root chain.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_reg[0] <= ps_reg;
            for (int k = 1; k < GW; k++)
            begin
                rs_reg[k] <= rs_reg[k-1];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_gap_reg    <= rg[GW];
            out_t1_reg     <= rs_reg[GW-1].t1;
            out_t2_reg     <= rs_reg[GW-1].t2;
            out_status_reg <= rs_reg[GW-1].status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign gap_length   = out_gap_reg;
    assign param_first  = out_t1_reg;
    assign param_second = out_t2_reg;
    assign status       = out_status_reg;

endmodule
`default_nettype wire

// File: hdl/rrcd_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rrcd_div_cell
// One restoring division step: shifts one dividend bit into the partial
// remainder and one quotient bit into the low word.
// ============================================================================
module rrcd_div_cell
    import rrcd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [RW-1:0] den_in,
    input  wire logic [RW-1:0] r_in,
    input  wire logic [QW-1:0] x_in,
    output logic      [RW-1:0] den_out,
    output logic      [RW-1:0] r_out,
    output logic      [QW-1:0] x_out
);

    logic [RW-1:0] den_reg;
    logic [RW-1:0] r_reg;
    logic [QW-1:0] x_reg;
    logic [RW:0]   trial_w;
    logic [RW:0]   diff_w;
    logic          take_w;

    // Trial subtraction of the divisor from the shifted remainder.
    assign trial_w = {r_in, x_in[QW-1]};
    assign diff_w  = trial_w - {1'b0, den_in};
    assign take_w  = trial_w >= {1'b0, den_in};

    // Step registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            r_reg   <= take_w ? diff_w[RW-1:0] : trial_w[RW-1:0];
            x_reg   <= {x_in[QW-2:0], take_w};
        end
    end

    assign den_out = den_reg;
    assign r_out   = r_reg;
    assign x_out   = x_reg;

endmodule
`default_nettype wire

// File: hdl/rrcd_root_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rrcd_root_cell
// One bit of the rounded square root: keeps bit BIT of g when (2g-1)^2
// stays at or below the scaled ratio.
// ============================================================================
module rrcd_root_cell
    import rrcd_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [GW-1:0] g_in,
    input  wire logic [QW-1:0] q_in,
    output logic      [GW-1:0] g_out,
    output logic      [QW-1:0] q_out
);

    logic [GW-1:0]     g_reg;
    logic [QW-1:0]     q_reg;
    logic [GW-1:0]     cand_w;
    logic [GW:0]       odd_w;
    logic [2*GW+1:0]   sq_w;
    logic              take_w;

    // Candidate with this bit set, then (2c-1)^2 against the ratio.
    assign cand_w = g_in | (GW'(1) << BIT);
    assign odd_w  = {cand_w, 1'b0} - (GW+1)'(1);
    assign sq_w   = odd_w * odd_w;
    assign take_w = QW'(sq_w) <= q_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg <= take_w ? cand_w : g_in;
            q_reg <= q_in;
        end
    end

    assign g_out = g_reg;
    assign q_out = q_reg;

endmodule
`default_nettype wire

// File: hdl/rrcd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rrcd_checker
// Port level checks of the closest distance pipeline, bound to the top level.
// ============================================================================
module rrcd_checker
    import rrcd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic        [17:0] gap_length,
    input wire logic signed [23:0] param_first,
    input wire logic signed [23:0] param_second,
    input wire logic        [1:0]  status
);

    // A held transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gap_length)
            && $stable(param_first) && $stable(param_second) && $stable(status))
        else $error("output transaction changed while stalled");

    // With an empty output register the input is never stalled.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output register");

    // A held result freezes the pipeline.
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while pipeline frozen");

    // Zero first direction gives a saturated gap and zero parameters.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_DEGEN) |->
            (gap_length == GAP_MAX) && (param_first == '0) && (param_second == '0))
        else $error("degenerate result malformed");

    // Parallel lines give zero parameters.
    a_parallel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_PARALLEL) |->
            (param_first == '0) && (param_second == '0))
        else $error("parallel result has nonzero parameters");

endmodule

bind ray_ray_closest_distance rrcd_checker u_rrcd_checker (.*);
`default_nettype wire
